// File: design/touch_gesture_classifier_top_assert.svh
// Assertion macros for the touch gesture classifier.
// Needs clk and arst_n in the scope of the including module.
`ifndef TOUCH_GESTURE_CLASSIFIER_TOP_ASSERT_SVH
`define TOUCH_GESTURE_CLASSIFIER_TOP_ASSERT_SVH

// same-cycle implication
`define TGC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TGC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/tgc_pkg.sv
// Package for the touch gesture classifier: phase, gesture and register codes,
// configuration record and reset values. No dependencies.
`timescale 1ns / 1ps

package tgc_pkg;

	localparam int COORD_WIDTH_DEF = 12;
	localparam int CFG_W           = 12;
	localparam int MAXPT_W         = 4;
	localparam int STATUS_W        = 8;
	localparam int CFG_IDX_W       = 3;
	localparam int READY_BIT       = 7;

	typedef enum logic [2:0] {
		PH_NONE      = 3'd0,
		PH_DOWN      = 3'd1,
		PH_UP        = 3'd2,
		PH_SLIDE     = 3'd3,
		PH_SLIDE_END = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		G_NONE  = 3'd0,
		G_TAP   = 3'd1,
		G_RIGHT = 3'd2,
		G_LEFT  = 3'd3,
		G_DOWN  = 3'd4,
		G_UP    = 3'd5
	} gesture_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SLIDE_THRESH = 3'd0,
		REG_MAX_POINTS   = 3'd1,
		REG_WIPE_LOCK_X  = 3'd2,
		REG_WIPE_RANGE_X = 3'd3,
		REG_WIPE_LOCK_Y  = 3'd4,
		REG_WIPE_RANGE_Y = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0]   slide_thresh;
		logic [MAXPT_W-1:0] max_points;
		logic [CFG_W-1:0]   wipe_lock_x;
		logic [CFG_W-1:0]   wipe_range_x;
		logic [CFG_W-1:0]   wipe_lock_y;
		logic [CFG_W-1:0]   wipe_range_y;
	} cfg_t;

	localparam logic [CFG_W-1:0]   SLIDE_THRESH_RST = 12'd6;
	localparam logic [MAXPT_W-1:0] MAX_POINTS_RST   = 4'd5;
	localparam logic [CFG_W-1:0]   WIPE_LOCK_X_RST  = 12'd40;
	localparam logic [CFG_W-1:0]   WIPE_RANGE_X_RST = 12'd90;
	localparam logic [CFG_W-1:0]   WIPE_LOCK_Y_RST  = 12'd22;
	localparam logic [CFG_W-1:0]   WIPE_RANGE_Y_RST = 12'd51;

endpackage

// File: design/tgc_step.sv
// Next-state logic for one touch report: phase tracking, coordinate capture
// and tap/wipe judging. Depends on tgc_pkg.
`timescale 1ns / 1ps

module tgc_step #(
	parameter int COORD_WIDTH = tgc_pkg::COORD_WIDTH_DEF
) (
	input  tgc_pkg::cfg_t                  cfg,
	input  tgc_pkg::phase_t                phase,
	input  tgc_pkg::gesture_t              gesture,
	input  logic [COORD_WIDTH-1:0]         start_x,
	input  logic [COORD_WIDTH-1:0]         start_y,
	input  logic [COORD_WIDTH-1:0]         last_x,
	input  logic [COORD_WIDTH-1:0]         last_y,
	input  logic                           irq_seen,
	input  logic                           ext_ack,
	input  logic [tgc_pkg::STATUS_W-1:0]   status_byte,
	input  logic [COORD_WIDTH-1:0]         first_x,
	input  logic [COORD_WIDTH-1:0]         first_y,
	output tgc_pkg::phase_t                phase_d,
	output tgc_pkg::gesture_t              gesture_d,
	output logic [COORD_WIDTH-1:0]         start_x_d,
	output logic [COORD_WIDTH-1:0]         start_y_d,
	output logic [COORD_WIDTH-1:0]         last_x_d,
	output logic [COORD_WIDTH-1:0]         last_y_d,
	output logic [COORD_WIDTH:0]           travel_x,
	output logic [COORD_WIDTH:0]           travel_y
);
	import tgc_pkg::*;

	localparam int DW    = COORD_WIDTH + 1;
	localparam int CMP_W = (DW > CFG_W + 1) ? DW : CFG_W + 1;

	logic signed [DW-1:0] mx, my, dx, dy;
	logic [DW-1:0]        mx_mag, my_mag, dx_mag, dy_mag;
	logic [MAXPT_W-1:0]   count;
	logic                 count_ok, moved, lock_x_ok, lock_y_ok;
	logic                 far_x, far_y;

	// movement since last tracked point
	assign mx     = $signed({1'b0, first_x}) - $signed({1'b0, last_x});
	assign my     = $signed({1'b0, first_y}) - $signed({1'b0, last_y});
	assign mx_mag = mx[DW-1] ? DW'(-mx) : DW'(mx);
	assign my_mag = my[DW-1] ? DW'(-my) : DW'(my);
	assign moved  = (CMP_W'(mx_mag) >= CMP_W'(cfg.slide_thresh)) ||
	                (CMP_W'(my_mag) >= CMP_W'(cfg.slide_thresh));

	// wipe judging only runs when coordinates are left untouched, so use held state
	assign dx     = $signed({1'b0, last_x}) - $signed({1'b0, start_x});
	assign dy     = $signed({1'b0, last_y}) - $signed({1'b0, start_y});
	assign dx_mag = dx[DW-1] ? DW'(-dx) : DW'(dx);
	assign dy_mag = dy[DW-1] ? DW'(-dy) : DW'(dy);
	assign lock_x_ok = CMP_W'(dy_mag) < CMP_W'(cfg.wipe_lock_x);
	assign lock_y_ok = CMP_W'(dx_mag) < CMP_W'(cfg.wipe_lock_y);
	assign far_x     = CMP_W'(dx_mag) > CMP_W'(cfg.wipe_range_x);
	assign far_y     = CMP_W'(dy_mag) > CMP_W'(cfg.wipe_range_y);

	assign count    = status_byte[MAXPT_W-1:0];
	assign count_ok = (count != '0) && (count <= cfg.max_points);

	always_comb begin
		phase_d   = phase;
		gesture_d = ext_ack ? G_NONE : gesture;
		start_x_d = start_x;
		start_y_d = start_y;
		last_x_d  = last_x;
		last_y_d  = last_y;
		if (irq_seen) begin
			if (status_byte[READY_BIT]) begin
				if (count_ok) begin
					if (phase == PH_NONE || phase == PH_UP || phase == PH_SLIDE_END) begin
						phase_d   = PH_DOWN;
						start_x_d = first_x;
						start_y_d = first_y;
						last_x_d  = first_x;
						last_y_d  = first_y;
					end else if (phase == PH_SLIDE || moved) begin
						phase_d  = PH_SLIDE;
						last_x_d = first_x;
						last_y_d = first_y;
					end
				end else begin
					case (phase)
						PH_SLIDE:     phase_d = PH_SLIDE_END;
						PH_DOWN:      phase_d = PH_UP;
						PH_SLIDE_END: phase_d = PH_SLIDE_END;
						default:      phase_d = PH_NONE;
					endcase
				end
			end
			if (gesture_d == G_NONE) begin
				if (phase_d == PH_UP) begin
					gesture_d = G_TAP;
				end else if (phase_d == PH_SLIDE_END) begin
					if (lock_x_ok && far_x)
						gesture_d = dx[DW-1] ? G_LEFT : G_RIGHT;
					if (lock_y_ok && far_y)
						gesture_d = dy[DW-1] ? G_UP : G_DOWN;
					phase_d = PH_NONE;
				end
			end
		end
	end

	assign travel_x = {1'b0, last_x_d} - {1'b0, start_x_d};
	assign travel_y = {1'b0, last_y_d} - {1'b0, start_y_d};

endmodule

// File: design/touch_gesture_classifier_top.sv
// Touch gesture classifier top level: stream ports, input and result registers,
// configuration registers and tracked state. Depends on tgc_pkg, tgc_step.
`timescale 1ns / 1ps

// One report in, one result out, one transaction per cycle when the output is
// not stalled. A report is captured into the input register, the whole phase
// update and gesture judgement run as combinational logic, and the result is
// loaded into the output register once the output register is free or drained.
// Configuration writes are always taken (cfg_ready is tied high); indexes beyond
// the last register are ignored. A pending gesture stays on gesture_out until a
// report with ext_ack set clears it.
module touch_gesture_classifier_top #(
	parameter int COORD_WIDTH = tgc_pkg::COORD_WIDTH_DEF,
	localparam int IN_BITS     = 2 + tgc_pkg::STATUS_W + 2 * COORD_WIDTH,
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS    = 6 + 4 * COORD_WIDTH + 2,
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// irq_seen, ext_ack, status_byte, first_x, first_y
	input  logic [IN_TDATA_W-1:0]            s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// touch_phase_out, gesture_out, cur_x, cur_y, travel_x, travel_y
	output logic [OUT_TDATA_W-1:0]           m_axis_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tgc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tgc_pkg::CFG_W-1:0]        cfg_data
);
	import tgc_pkg::*;

	localparam int CW = COORD_WIDTH;

	cfg_t     cfg_q;
	phase_t   phase_q, phase_d;
	gesture_t gesture_q, gesture_d;
	logic [CW-1:0] start_x_q, start_y_q, last_x_q, last_y_q;
	logic [CW-1:0] start_x_d, start_y_d, last_x_d, last_y_d;
	logic [CW:0]   travel_x, travel_y;

	logic                valid_s1;
	logic                irq_s1, ack_s1;
	logic [STATUS_W-1:0] status_s1;
	logic [CW-1:0]       px_s1, py_s1;
	logic                adv;
	logic                out_valid_q;
	logic [OUT_BITS-1:0] out_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slide_thresh <= SLIDE_THRESH_RST;
			cfg_q.max_points   <= MAX_POINTS_RST;
			cfg_q.wipe_lock_x  <= WIPE_LOCK_X_RST;
			cfg_q.wipe_range_x <= WIPE_RANGE_X_RST;
			cfg_q.wipe_lock_y  <= WIPE_LOCK_Y_RST;
			cfg_q.wipe_range_y <= WIPE_RANGE_Y_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SLIDE_THRESH: cfg_q.slide_thresh <= cfg_data;
				REG_MAX_POINTS:   cfg_q.max_points   <= cfg_data[MAXPT_W-1:0];
				REG_WIPE_LOCK_X:  cfg_q.wipe_lock_x  <= cfg_data;
				REG_WIPE_RANGE_X: cfg_q.wipe_range_x <= cfg_data;
				REG_WIPE_LOCK_Y:  cfg_q.wipe_lock_y  <= cfg_data;
				REG_WIPE_RANGE_Y: cfg_q.wipe_range_y <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake: stage 1 moves on whenever the output register is free or drained
	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign m_axis_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			irq_s1    <= s_axis_tdata[0];
			ack_s1    <= s_axis_tdata[1];
			status_s1 <= s_axis_tdata[2 +: STATUS_W];
			px_s1     <= s_axis_tdata[2 + STATUS_W +: CW];
			py_s1     <= s_axis_tdata[2 + STATUS_W + CW +: CW];
		end
	end

	tgc_step #(
		.COORD_WIDTH(CW)
	) u_step (
		.cfg        (cfg_q),
		.phase      (phase_q),
		.gesture    (gesture_q),
		.start_x    (start_x_q),
		.start_y    (start_y_q),
		.last_x     (last_x_q),
		.last_y     (last_y_q),
		.irq_seen   (irq_s1),
		.ext_ack    (ack_s1),
		.status_byte(status_s1),
		.first_x    (px_s1),
		.first_y    (py_s1),
		.phase_d    (phase_d),
		.gesture_d  (gesture_d),
		.start_x_d  (start_x_d),
		.start_y_d  (start_y_d),
		.last_x_d   (last_x_d),
		.last_y_d   (last_y_d),
		.travel_x   (travel_x),
		.travel_y   (travel_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_NONE;
			gesture_q <= G_NONE;
			start_x_q <= '0;
			start_y_q <= '0;
			last_x_q  <= '0;
			last_y_q  <= '0;
		end else if (adv) begin
			phase_q   <= phase_d;
			gesture_q <= gesture_d;
			start_x_q <= start_x_d;
			start_y_q <= start_y_d;
			last_x_q  <= last_x_d;
			last_y_q  <= last_y_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= {travel_y, travel_x, last_y_d, last_x_d, gesture_d, phase_d};
		end
	end

	assign m_axis_tdata = OUT_TDATA_W'(out_q);

	`include "touch_gesture_classifier_top_assert.svh"

	// a latched gesture only goes away through an acknowledged report
	`TGC_ASSERT_NEXT(a_gesture_held, gesture_q != G_NONE && !(adv && ack_s1), $stable(gesture_q), "pending gesture changed without acknowledge")
	// a freshly latched tap always comes with the up phase
	`TGC_ASSERT_NOW(a_tap_phase, gesture_q == G_TAP && $past(gesture_q) != G_TAP, phase_q == PH_UP, "tap latched outside up phase")
	// result register mirrors the tracked state it was loaded from
	`TGC_ASSERT_NEXT(a_out_state, adv, (out_q[5:0] == {gesture_q, phase_q}), "result off state")

endmodule
